// ----- hdl/rpc_pkg.sv -----
// Shared types and constants of the radar pulse compression block.
package rpc_pkg;

    localparam int unsigned MAX_SAMPLES = 4096;

    localparam int unsigned TAP_IDX_W = 6;
    localparam int unsigned VAL_W     = 16;
    localparam int unsigned PROD_W    = 33;
    localparam int unsigned ACC_W     = 39;
    localparam int unsigned BIN_W     = 12;
    localparam int unsigned TCNT_W    = 7;
    localparam int unsigned SCNT_W    = 13;
    localparam int unsigned VIDX_W    = 13;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 96;

    typedef enum logic [0:0] {
        CMD_TAP    = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        REG_TAP_COUNT    = 1'b0,
        REG_SAMPLE_COUNT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_CALC  = 2'd1,
        S_EMIT  = 2'd2,
        S_DRAIN = 2'd3
    } t_state;

    typedef struct packed {
        logic signed [VAL_W-1:0] re;
        logic signed [VAL_W-1:0] im;
    } t_iq;

    typedef struct packed {
        logic active;
        logic head;
    } t_cell_flags;

    typedef struct packed {
        logic             shift;
        logic             drain;
        logic             load_out;
        logic             last_bin;
        logic [BIN_W-1:0] bin;
    } t_seq_ctl;

endpackage

// ----- hdl/radar_pulse_compression_top.sv -----
// Top level of the complex matched-filter pulse compression block.
//
// Usage: the slave stream carries commands. With tuser low, a transfer loads one
// complex Q1.15 filter tap at the given tap index; with tuser high, it delivers one
// I/Q sample of the current pulse. The master stream carries range bins, one per
// transfer, with tlast marking bin N-1 of the pulse. The configuration channel
// writes the tap count L (index 0) and the sample count N (index 1); either write
// restarts the pulse, while loaded taps are kept. Values outside 1..MAX_TAPS and
// 1..4096 are clamped where they are used.
// Sequence: a tap load, or a sample that yields no bin and does not end the pulse, leaves
// the sequencer idle. A sample that yields a bin enters the sample chain, then its sum
// ripples from cell L-1 down to cell 0, then the sum moves to the output register. The
// last sample of a pulse then drains zeros through the chain: zeros are shifted ahead of
// the first tail bin, and one zero ahead of each later tail bin.
// A finished bin waits in the output register, so a new command is taken while the
// receiver stalls; a bin that finds the register still full waits in the chain.
// Reset clears the taps to zero, L and N to one and the sample index to zero.
module radar_pulse_compression_top #(
    parameter int unsigned MAX_TAPS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave stream.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: tap_index[5:0], value_re[21:6], value_im[37:22], zero [39:38].
    input  logic [rpc_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: command (0 loads a tap, 1 delivers a sample).
    input  logic                              i_s_tuser,
    // Master stream.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: range_bin[11:0], out_re[50:12], out_im[89:51], zero [95:90].
    output logic [rpc_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tlast,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [rpc_pkg::SCNT_W-1:0]        i_cfg_data
);

    localparam int unsigned PadW = rpc_pkg::OUT_DATA_W - rpc_pkg::BIN_W - 2 * rpc_pkg::ACC_W;

    // Configuration registers and their clamped values.
    logic [rpc_pkg::TCNT_W-1:0] r_tap_count;
    logic [rpc_pkg::SCNT_W-1:0] r_sample_count;
    logic [rpc_pkg::TCNT_W-1:0] w_taps;
    logic [rpc_pkg::SCNT_W-1:0] w_samples;
    logic                       w_cfg_write;

    // Input side decode.
    logic                           w_in_accept;
    logic                           w_smp_accept;
    logic                           w_tap_accept;
    rpc_pkg::t_cmd                  w_cmd;
    logic [rpc_pkg::TAP_IDX_W-1:0]  w_tap_idx;
    rpc_pkg::t_iq                   w_val;

    // Sequencer interface.
    logic                 w_ready;
    logic                 w_out_free;
    rpc_pkg::t_seq_ctl    w_ctl;

    // Cell chain: samples move up from cell 0, sums move down to cell 0.
    rpc_pkg::t_iq                       w_smp    [MAX_TAPS+1];
    logic signed [rpc_pkg::ACC_W-1:0]   w_acc_re [MAX_TAPS+1];
    logic signed [rpc_pkg::ACC_W-1:0]   w_acc_im [MAX_TAPS+1];
    logic [MAX_TAPS-1:0]                w_head;

    // Output register.
    logic                              r_m_valid;
    logic [rpc_pkg::BIN_W-1:0]         r_m_bin;
    logic signed [rpc_pkg::ACC_W-1:0]  r_m_re;
    logic signed [rpc_pkg::ACC_W-1:0]  r_m_im;
    logic                              r_m_last;

    // Configuration is always taken; the user must write it only while the block is idle (unenforced).
    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count    <= rpc_pkg::TCNT_W'(1);
            r_sample_count <= rpc_pkg::SCNT_W'(1);
        end else if (w_cfg_write) begin
            unique case (rpc_pkg::t_reg_idx'(i_cfg_index))
                rpc_pkg::REG_TAP_COUNT:    r_tap_count    <= i_cfg_data[rpc_pkg::TCNT_W-1:0];
                rpc_pkg::REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data;
                default:                   r_tap_count    <= r_tap_count;
            endcase
        end
    end

    always_comb begin
        if (r_tap_count == '0) begin
            w_taps = rpc_pkg::TCNT_W'(1);
        end else if (r_tap_count > rpc_pkg::TCNT_W'(MAX_TAPS)) begin
            w_taps = rpc_pkg::TCNT_W'(MAX_TAPS);
        end else begin
            w_taps = r_tap_count;
        end
        if (r_sample_count == '0) begin
            w_samples = rpc_pkg::SCNT_W'(1);
        end else if (r_sample_count > rpc_pkg::SCNT_W'(rpc_pkg::MAX_SAMPLES)) begin
            w_samples = rpc_pkg::SCNT_W'(rpc_pkg::MAX_SAMPLES);
        end else begin
            w_samples = r_sample_count;
        end
    end

    // Commands are taken whenever the sequencer is between items.
    assign o_s_tready   = w_ready;
    assign w_in_accept  = i_s_tvalid && w_ready;
    assign w_cmd        = rpc_pkg::t_cmd'(i_s_tuser);
    assign w_tap_idx    = i_s_tdata[rpc_pkg::TAP_IDX_W-1:0];
    assign w_val.re     = i_s_tdata[rpc_pkg::TAP_IDX_W +: rpc_pkg::VAL_W];
    assign w_val.im     = i_s_tdata[rpc_pkg::TAP_IDX_W + rpc_pkg::VAL_W +: rpc_pkg::VAL_W];
    assign w_smp_accept = w_in_accept && (w_cmd == rpc_pkg::CMD_SAMPLE);
    assign w_tap_accept = w_in_accept && (w_cmd == rpc_pkg::CMD_TAP);

    assign w_out_free = !r_m_valid || i_m_tready;

    rpc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_smp_accept (w_smp_accept),
        .i_cfg_write  (w_cfg_write),
        .i_taps       (w_taps),
        .i_samples    (w_samples),
        .i_out_free   (w_out_free),
        .o_ready      (w_ready),
        .o_ctl        (w_ctl)
    );

    // Zeros enter the chain while the tail of the pulse drains.
    assign w_smp[0]           = w_ctl.drain ? '0 : w_val;
    assign w_acc_re[MAX_TAPS] = '0;
    assign w_acc_im[MAX_TAPS] = '0;

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        localparam logic [rpc_pkg::TCNT_W-1:0] CellNum = rpc_pkg::TCNT_W'(g);

        rpc_pkg::t_cell_flags w_flags;
        logic                 w_tap_we;

        // Cell L-1 starts each sum and cells below L contribute to it.
        assign w_head[g]      = (w_taps == CellNum + rpc_pkg::TCNT_W'(1));
        assign w_flags.head   = w_head[g];
        assign w_flags.active = (CellNum < w_taps);
        assign w_tap_we       = w_tap_accept && (w_tap_idx == rpc_pkg::TAP_IDX_W'(g));

        rpc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tap_we (w_tap_we),
            .i_tap    (w_val),
            .i_shift  (w_ctl.shift),
            .i_smp    (w_smp[g]),
            .o_smp    (w_smp[g+1]),
            .i_flags  (w_flags),
            .i_acc_re (w_acc_re[g+1]),
            .i_acc_im (w_acc_im[g+1]),
            .o_acc_re (w_acc_re[g]),
            .o_acc_im (w_acc_im[g])
        );
    end

    // The finished sum at cell 0 is moved into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load_out) begin
            r_m_bin  <= w_ctl.bin;
            r_m_re   <= w_acc_re[0];
            r_m_im   <= w_acc_im[0];
            r_m_last <= w_ctl.last_bin;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {PadW'(0), r_m_im, r_m_re, r_m_bin};
    assign o_m_tlast  = r_m_last;

    // Exactly one cell of the chain starts the sum.
    a_one_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_head))
        else $error("cell chain does not have exactly one head cell");

endmodule

// ----- hdl/rpc_cell.sv -----
// One cell of the correlator chain: a filter tap, a sample stage and a partial sum stage.
module rpc_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tap_we,
    input  rpc_pkg::t_iq                       i_tap,
    input  logic                               i_shift,
    input  rpc_pkg::t_iq                       i_smp,
    output rpc_pkg::t_iq                       o_smp,
    input  rpc_pkg::t_cell_flags               i_flags,
    input  logic signed [rpc_pkg::ACC_W-1:0]   i_acc_re,
    input  logic signed [rpc_pkg::ACC_W-1:0]   i_acc_im,
    output logic signed [rpc_pkg::ACC_W-1:0]   o_acc_re,
    output logic signed [rpc_pkg::ACC_W-1:0]   o_acc_im
);

    localparam int unsigned ExtW = rpc_pkg::ACC_W - rpc_pkg::PROD_W;

    rpc_pkg::t_iq r_tap;
    rpc_pkg::t_iq r_smp;

    logic signed [rpc_pkg::PROD_W-1:0] r_prod_re;
    logic signed [rpc_pkg::PROD_W-1:0] r_prod_im;
    logic signed [rpc_pkg::PROD_W-1:0] n_prod_re;
    logic signed [rpc_pkg::PROD_W-1:0] n_prod_im;
    logic signed [rpc_pkg::ACC_W-1:0]  r_acc_re;
    logic signed [rpc_pkg::ACC_W-1:0]  r_acc_im;
    logic signed [rpc_pkg::ACC_W-1:0]  n_acc_re;
    logic signed [rpc_pkg::ACC_W-1:0]  n_acc_im;

    logic signed [2*rpc_pkg::VAL_W-1:0] w_rr;
    logic signed [2*rpc_pkg::VAL_W-1:0] w_ii;
    logic signed [2*rpc_pkg::VAL_W-1:0] w_ri;
    logic signed [2*rpc_pkg::VAL_W-1:0] w_ir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (i_tap_we) begin
            r_tap <= i_tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_smp <= i_smp;
        end
    end

    // Complex product of tap and sample, registered before it joins the sum.
    always_comb begin
        w_rr      = r_tap.re * r_smp.re;
        w_ii      = r_tap.im * r_smp.im;
        w_ri      = r_tap.re * r_smp.im;
        w_ir      = r_tap.im * r_smp.re;
        n_prod_re = {w_rr[2*rpc_pkg::VAL_W-1], w_rr} - {w_ii[2*rpc_pkg::VAL_W-1], w_ii};
        n_prod_im = {w_ri[2*rpc_pkg::VAL_W-1], w_ri} + {w_ir[2*rpc_pkg::VAL_W-1], w_ir};
    end

    // The head cell starts a fresh sum; cells past the filter length add nothing.
    always_comb begin
        n_acc_re = (i_flags.head ? '0 : i_acc_re)
                 + (i_flags.active ? {{ExtW{r_prod_re[rpc_pkg::PROD_W-1]}}, r_prod_re} : '0);
        n_acc_im = (i_flags.head ? '0 : i_acc_im)
                 + (i_flags.active ? {{ExtW{r_prod_im[rpc_pkg::PROD_W-1]}}, r_prod_im} : '0);
    end

    always_ff @(posedge i_clk) begin
        r_prod_re <= n_prod_re;
        r_prod_im <= n_prod_im;
        r_acc_re  <= n_acc_re;
        r_acc_im  <= n_acc_im;
    end

    assign o_smp    = r_smp;
    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

// ----- hdl/rpc_seq.sv -----
// Sequencer that steps the cell chain through sample entry, sum settling, bin output and tail drain.
module rpc_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_smp_accept,
    input  logic                          i_cfg_write,
    input  logic [rpc_pkg::TCNT_W-1:0]    i_taps,
    input  logic [rpc_pkg::SCNT_W-1:0]    i_samples,
    input  logic                          i_out_free,
    output logic                          o_ready,
    output rpc_pkg::t_seq_ctl             o_ctl
);

    rpc_pkg::t_state r_state;
    rpc_pkg::t_state n_state;

    logic [rpc_pkg::BIN_W-1:0]  r_idx;
    logic [rpc_pkg::BIN_W-1:0]  n_idx;
    logic [rpc_pkg::VIDX_W-1:0] r_v;
    logic [rpc_pkg::VIDX_W-1:0] n_v;
    logic                       r_last;
    logic                       n_last;
    logic [rpc_pkg::TCNT_W-1:0] r_cnt;
    logic [rpc_pkg::TCNT_W-1:0] n_cnt;

    logic [rpc_pkg::VIDX_W-1:0] w_taps_m1;
    logic [rpc_pkg::VIDX_W-1:0] w_samples_m1;
    logic [rpc_pkg::VIDX_W-1:0] w_idx_ext;
    logic [rpc_pkg::VIDX_W-1:0] w_v_next;
    logic [rpc_pkg::VIDX_W-1:0] w_bin;
    logic                       w_at_end;
    logic                       w_idx_full;
    logic                       w_final;

    // The chain index v counts samples and drained zeros; bin v-(L-1) is ready once v >= L-1.
    always_comb begin
        w_taps_m1    = rpc_pkg::VIDX_W'(i_taps) - rpc_pkg::VIDX_W'(1);
        w_samples_m1 = rpc_pkg::VIDX_W'(i_samples) - rpc_pkg::VIDX_W'(1);
        w_idx_ext    = rpc_pkg::VIDX_W'(r_idx);
        w_v_next     = r_v + rpc_pkg::VIDX_W'(1);
        w_bin        = r_v - w_taps_m1;
        w_at_end     = (w_idx_ext == w_samples_m1);
        w_idx_full   = (w_idx_ext >= w_taps_m1);
        w_final      = (w_bin == w_samples_m1);
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_v     = r_v;
        n_last  = r_last;
        n_cnt   = r_cnt;
        unique case (r_state)
            rpc_pkg::S_IDLE: begin
                if (i_smp_accept) begin
                    n_v    = w_idx_ext;
                    n_last = w_at_end;
                    n_idx  = w_at_end ? '0 : r_idx + rpc_pkg::BIN_W'(1);
                    n_cnt  = i_taps;
                    if (w_idx_full) begin
                        n_state = rpc_pkg::S_CALC;
                    end else if (w_at_end) begin
                        n_state = rpc_pkg::S_DRAIN;
                    end
                end
            end
            rpc_pkg::S_CALC: begin
                if (r_cnt == '0) begin
                    n_state = rpc_pkg::S_EMIT;
                end else begin
                    n_cnt = r_cnt - rpc_pkg::TCNT_W'(1);
                end
            end
            rpc_pkg::S_EMIT: begin
                if (i_out_free) begin
                    n_state = (r_last && !w_final) ? rpc_pkg::S_DRAIN : rpc_pkg::S_IDLE;
                end
            end
            rpc_pkg::S_DRAIN: begin
                n_v = w_v_next;
                if (w_v_next >= w_taps_m1) begin
                    n_state = rpc_pkg::S_CALC;
                    n_cnt   = i_taps;
                end
            end
            default: begin
                n_state = rpc_pkg::S_IDLE;
            end
        endcase
        if (i_cfg_write) begin
            n_idx = '0;
        end
    end

    always_comb begin
        o_ready        = (r_state == rpc_pkg::S_IDLE);
        o_ctl.shift    = ((r_state == rpc_pkg::S_IDLE) && i_smp_accept)
                       || (r_state == rpc_pkg::S_DRAIN);
        o_ctl.drain    = (r_state == rpc_pkg::S_DRAIN);
        o_ctl.load_out = (r_state == rpc_pkg::S_EMIT) && i_out_free;
        o_ctl.last_bin = w_final;
        o_ctl.bin      = w_bin[rpc_pkg::BIN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpc_pkg::S_IDLE;
            r_idx   <= '0;
            r_v     <= '0;
            r_last  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_v     <= n_v;
            r_last  <= n_last;
            r_cnt   <= n_cnt;
        end
    end

    // Between items the sample index always lies inside the pulse.
    a_idx_in_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpc_pkg::S_IDLE) |-> (w_idx_ext <= w_samples_m1))
        else $error("sample index beyond pulse length");

    // A bin is only put out once the chain holds a full window.
    a_bin_not_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpc_pkg::S_EMIT) |-> (r_v >= w_taps_m1))
        else $error("bin put out before window was full");

    // The final bin of a pulse ends the tail.
    a_tail_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.load_out && o_ctl.last_bin) |=> (r_state == rpc_pkg::S_IDLE))
        else $error("sequencer kept running after final bin");

endmodule

// ----- sim/rpc_checker.sv -----
// Checker that predicts and compares the range bins of the pulse compression block.
`timescale 1ns / 100ps

module rpc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [rpc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [rpc_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tlast,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [rpc_pkg::SCNT_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_bins_checked
);
    import rpc_pkg::*;

    localparam int TAP_SLOTS = 64;

    typedef struct {
        logic [BIN_W-1:0]        bin;
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
        logic                    last;
    } t_range_bin;

    t_range_bin              expected_bins[$];
    logic signed [VAL_W-1:0] tap_re [TAP_SLOTS];
    logic signed [VAL_W-1:0] tap_im [TAP_SLOTS];
    logic signed [VAL_W-1:0] win_re [TAP_SLOTS];
    logic signed [VAL_W-1:0] win_im [TAP_SLOTS];
    logic [BIN_W-1:0]        sample_pos;
    logic [TCNT_W-1:0]       tap_count_reg;
    logic [SCNT_W-1:0]       sample_count_reg;
    int                      fail_count;
    int                      bins_checked;
    int                      shown;

    // Register values are clamped only where they are used.
    function automatic int taps_in_use();
        if (tap_count_reg == 0) return 1;
        if (tap_count_reg > TAP_SLOTS) return TAP_SLOTS;
        return int'(tap_count_reg);
    endfunction

    function automatic int samples_in_pulse();
        if (sample_count_reg == 0) return 1;
        if (sample_count_reg > MAX_SAMPLES) return MAX_SAMPLES;
        return int'(sample_count_reg);
    endfunction

    // Correlates bin r against the taps as they stand now; samples past the pulse end are zero.
    function automatic void correlate_bin(int r, int ntaps, int nsamp);
        longint     acc_re;
        longint     acc_im;
        int         k;
        int         j;
        int         s;
        t_range_bin b;
        acc_re = 0;
        acc_im = 0;
        for (k = 0; k < ntaps; k++) begin
            j = r + ntaps - 1 - k;
            if (j < nsamp) begin
                s = j % TAP_SLOTS;
                acc_re += longint'(tap_re[k]) * longint'(win_re[s])
                        - longint'(tap_im[k]) * longint'(win_im[s]);
                acc_im += longint'(tap_re[k]) * longint'(win_im[s])
                        + longint'(tap_im[k]) * longint'(win_re[s]);
            end
        end
        b.bin  = r[BIN_W-1:0];
        b.re   = acc_re[ACC_W-1:0];
        b.im   = acc_im[ACC_W-1:0];
        b.last = (r == nsamp - 1);
        expected_bins.push_back(b);
    endfunction

    function automatic void take_sample(logic signed [VAL_W-1:0] re,
                                        logic signed [VAL_W-1:0] im);
        int ntaps;
        int nsamp;
        int pos;
        int r;
        ntaps = taps_in_use();
        nsamp = samples_in_pulse();
        pos   = int'(sample_pos);
        if (pos > nsamp - 1) pos = nsamp - 1;
        win_re[pos % TAP_SLOTS] = re;
        win_im[pos % TAP_SLOTS] = im;
        if (pos >= ntaps - 1) correlate_bin(pos - ntaps + 1, ntaps, nsamp);
        if (pos == nsamp - 1) begin
            // The last sample of the pulse also flushes every remaining tail bin.
            r = (pos >= ntaps - 1) ? pos - ntaps + 2 : 0;
            for (; r < nsamp; r++) correlate_bin(r, ntaps, nsamp);
            sample_pos = '0;
        end else begin
            sample_pos = pos + 1;
        end
    endfunction

    function automatic void check_bin();
        logic [BIN_W-1:0]        got_bin;
        logic signed [ACC_W-1:0] got_re;
        logic signed [ACC_W-1:0] got_im;
        t_range_bin              want;
        got_bin = i_m_tdata[BIN_W-1:0];
        got_re  = i_m_tdata[BIN_W +: ACC_W];
        got_im  = i_m_tdata[BIN_W + ACC_W +: ACC_W];
        if (expected_bins.size() == 0) begin
            fail_count++;
            if (shown < 10) begin
                $display("%0t: unexpected range bin %0d re %0d im %0d last %0b",
                         $realtime, got_bin, got_re, got_im, i_m_tlast);
                shown++;
            end
            return;
        end
        want = expected_bins.pop_front();
        bins_checked++;
        if (got_bin !== want.bin || got_re !== want.re || got_im !== want.im ||
            i_m_tlast !== want.last) begin
            fail_count++;
            if (shown < 10) begin
                $display("%0t: bin mismatch, expected bin %0d re %0d im %0d last %0b",
                         $realtime, want.bin, want.re, want.im, want.last);
                $display("%0t:                  got bin %0d re %0d im %0d last %0b",
                         $realtime, got_bin, got_re, got_im, i_m_tlast);
                shown++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bins.delete();
            for (int k = 0; k < TAP_SLOTS; k++) begin
                tap_re[k] = '0;
                tap_im[k] = '0;
                win_re[k] = '0;
                win_im[k] = '0;
            end
            sample_pos       = '0;
            tap_count_reg    = 1;
            sample_count_reg = 1;
            fail_count       = 0;
            bins_checked     = 0;
            shown            = 0;
        end else begin
            // A bin never leaves in the cycle its sample enters, so the output goes first.
            if (i_m_tvalid && i_m_tready) check_bin();
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_TAP_COUNT) begin
                    tap_count_reg = i_cfg_data[TCNT_W-1:0];
                end else begin
                    sample_count_reg = i_cfg_data;
                end
                sample_pos = '0;
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_TAP) begin
                    tap_re[i_s_tdata[TAP_IDX_W-1:0]] = i_s_tdata[TAP_IDX_W +: VAL_W];
                    tap_im[i_s_tdata[TAP_IDX_W-1:0]] = i_s_tdata[TAP_IDX_W + VAL_W +: VAL_W];
                end else begin
                    take_sample(i_s_tdata[TAP_IDX_W +: VAL_W],
                                i_s_tdata[TAP_IDX_W + VAL_W +: VAL_W]);
                end
            end
        end
        o_fail_count   = fail_count;
        o_pending      = expected_bins.size();
        o_bins_checked = bins_checked;
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top: drives taps, samples and register writes into the pulse compression block.
`timescale 1ns / 100ps

module tb;
    import rpc_pkg::*;

    // Long enough for the slowest run several times over.
    localparam longint RUN_LIMIT_NS = 64'd50_000_000;
    // A bin of the longest filter ripples out well within this, so it covers any work left over.
    localparam int     SETTLE       = 80;
    localparam int     RX_HOLD      = 400;
    localparam int     PHASE_ITEMS  = 115;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = 1'b0;
    logic [SCNT_W-1:0]     cfg_data = '0;

    int fail_count;
    int pending;
    int bins_checked;

    // Idling controls, changed per phase and per round.
    int send_idle_pct = 0;
    int stall_pct = 0;
    int rx_hold_left = 0;

    int items_sent = 0;
    int taps_sent = 0;
    int samples_sent = 0;
    int cfg_writes = 0;

    always #5 clk = ~clk;

    radar_pulse_compression_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rpc_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tlast      (m_tlast),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_bins_checked (bins_checked)
    );

    // Receiver: a long hold-off when one is requested, random stalls otherwise.
    always @(negedge clk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    // Field values lean toward the extremes so that full-scale products show up often.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic int clamp_taps(int raw);
        int low_bits;
        low_bits = raw & 'h7f;
        if (low_bits == 0) return 1;
        if (low_bits > 64) return 64;
        return low_bits;
    endfunction

    // Offers one item and returns at the falling edge after its transfer. The valid is left
    // high, so that a following item goes out back to back; stop_send lowers it.
    task automatic send_item(input t_cmd cmd, input logic [TAP_IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] re, input logic [VAL_W-1:0] im);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, im, re, idx};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (cmd == CMD_TAP) taps_sent++;
        else samples_sent++;
    endtask

    task automatic stop_send();
        s_tvalid <= 1'b0;
    endtask

    task automatic send_sample();
        send_item(CMD_SAMPLE, TAP_IDX_W'($urandom), pick_value(), pick_value());
    endtask

    // The extra falling edge keeps a second write from raising the valid in the same step.
    task automatic write_reg(input t_reg_idx idx, input logic [SCNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        cfg_writes++;
    endtask

    // Waits for every expected bin, then lets the chain finish any work that yields none.
    task automatic settle();
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Registers are only written with the block idle; either write restarts the pulse.
    task automatic configure(input int l_raw, input int n_raw);
        settle();
        if ($urandom_range(1) == 1) begin
            write_reg(REG_TAP_COUNT, l_raw[SCNT_W-1:0]);
            write_reg(REG_SAMPLE_COUNT, n_raw[SCNT_W-1:0]);
        end else begin
            write_reg(REG_SAMPLE_COUNT, n_raw[SCNT_W-1:0]);
            write_reg(REG_TAP_COUNT, l_raw[SCNT_W-1:0]);
        end
    endtask

    task automatic load_taps(input int ntaps);
        for (int k = 0; k < ntaps; k++) begin
            send_item(CMD_TAP, k[TAP_IDX_W-1:0], pick_value(), pick_value());
        end
    endtask

    // One random setting: mostly short filters and pulses, sometimes full-length filters,
    // and now and then a raw register value that has to be clamped.
    task automatic random_round(input int budget_end, input int phase_send,
                                input int phase_stall);
        int mode;
        int l_raw;
        int n_raw;
        int pulses;
        int p;
        int j;
        mode  = $urandom_range(9);
        l_raw = (mode == 0) ? $urandom_range(0, 8191) : $urandom_range(1, (mode < 3) ? 64 : 8);
        n_raw = $urandom_range(1, (mode < 3) ? 80 : 20);
        configure(l_raw, n_raw);
        send_idle_pct = ($urandom_range(3) == 0) ? 0 : phase_send;
        stall_pct     = ($urandom_range(3) == 0) ? 0 : phase_stall;
        // Now and then the old taps are kept, so stale entries get used.
        if ($urandom_range(3) != 0) load_taps(clamp_taps(l_raw));
        pulses = $urandom_range(1, 3);
        for (p = 0; p < pulses && items_sent < budget_end; p++) begin
            for (j = 0; j < n_raw && items_sent < budget_end; j++) begin
                // A stray tap load in the middle of a pulse takes effect at once.
                if ($urandom_range(11) == 0) begin
                    send_item(CMD_TAP, TAP_IDX_W'($urandom), pick_value(), pick_value());
                end
                send_sample();
            end
        end
        stop_send();
    endtask

    initial begin
        int send_pcts [4];
        int stall_pcts[4];
        int phase_end;
        send_pcts  = '{0, 55, 0, 29};
        stall_pcts = '{0, 0, 55, 29};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. With the reset values L = 1 and N = 1, so every sample is a whole
        // pulse of one bin; the first tap and the second sample are both the most negative value.
        send_item(CMD_TAP, 6'd0, 16'h8000, 16'h8000);
        send_sample();
        send_item(CMD_SAMPLE, 6'h3f, 16'h8000, 16'h8000);
        send_item(CMD_SAMPLE, 6'h00, 16'h7fff, 16'h7fff);
        // The top tap slot is stored but stays unused at these tap counts.
        send_item(CMD_TAP, 6'h3f, 16'h7fff, 16'h8000);
        send_item(CMD_TAP, 6'd1, 16'h7fff, 16'h0000);
        send_item(CMD_TAP, 6'd2, 16'h0000, 16'hffff);
        stop_send();

        // Short pulse: fewer samples than taps, so all bins come with the last sample.
        configure(3, 2);
        repeat (2) send_sample();
        stop_send();

        // A tap count of 127 clamps to the full 64 taps.
        configure(127, 5);
        repeat (5) send_sample();
        stop_send();

        // A tap changed in the middle of a pulse applies to the bins that follow.
        configure(2, 3);
        send_sample();
        send_item(CMD_TAP, 6'd1, 16'h8000, 16'h7fff);
        send_sample();
        send_sample();
        stop_send();

        // Zero taps clamp to one, and an all-ones sample count clamps to the maximum pulse.
        configure(0, 8191);
        repeat (4) send_sample();
        stop_send();

        // Back-pressure: the receiver holds off while samples keep coming, so the output
        // register and the chain fill up and the input has to stall.
        configure(4, 48);
        load_taps(4);
        rx_hold_left = RX_HOLD;
        repeat (48) send_sample();
        stop_send();
        // The sender pauses here until every bin of the burst has come out.
        settle();

        // Random part, one phase per idling pattern.
        for (int ph = 0; ph < 4; ph++) begin
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                random_round(phase_end, send_pcts[ph], stall_pcts[ph]);
            end
        end

        stop_send();
        settle();
        $display("Sent %0d transfers (%0d taps, %0d samples) over %0d register writes.",
                 items_sent, taps_sent, samples_sent, cfg_writes);
        $display("Checked %0d range bins under no idling, sender gaps, receiver stalls, both.",
                 bins_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Run timed out with %0d range bins outstanding.", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule
